/* src/pip_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types and constants for the point-in-polygon crossing-number core.
// ----------------------------------------------------------------------------
package pip_pkg;

  localparam int COORD_W      = 16;
  localparam int MAX_VERTICES = 16;
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int DIFF_W       = COORD_W + 1;
  localparam int PROD_W       = 2 * DIFF_W;
  localparam int REQ_W        = 2;
  localparam int IN_TDATA_W   = 2 * COORD_W;
  localparam int OUT_TDATA_W  = ((CNT_W + 2 + 7) / 8) * 8;

  typedef enum logic [REQ_W-1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_TEST   = 2'd2
  } req_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } vertex_t;

  // Control from the sequencer to the edge unit.
  typedef struct packed {
    logic clr;    // clear the crossing parity
    logic mul_l;  // form (px - xi) * dy
    logic mul_r;  // form (xj - xi) * (py - yi)
  } eu_ctl_t;

endpackage

/* src/pip_vtx_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_vtx_ram
// Vertex table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pip_vtx_ram
  import pip_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  vertex_t          wdata,
  input  logic [IDX_W-1:0] raddr,
  output vertex_t          rdata
);

  vertex_t mem [MAX_VERTICES];
  vertex_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* src/pip_edge_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_edge_unit
// Shared multiplier and comparator that decides, one edge at a time, whether
// the edge crosses the ray to the right of the point, and keeps the parity.
// ----------------------------------------------------------------------------
module pip_edge_unit
  import pip_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  eu_ctl_t ctl,
  input  vertex_t vi,
  input  vertex_t vj,
  input  vertex_t pt,
  output logic    parity
);

  logic signed [DIFF_W-1:0] dy;
  logic signed [DIFF_W-1:0] op_a;
  logic signed [DIFF_W-1:0] op_b;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] l_r;
  logic                     straddle;
  logic                     straddle_r;
  logic                     dy_pos_r;
  logic                     dy_neg_r;
  logic                     pend_r;
  logic                     parity_r;
  logic                     hit;

  assign dy       = DIFF_W'(vj.y) - DIFF_W'(vi.y);
  assign straddle = (vi.y > pt.y) != (vj.y > pt.y);

  always_comb begin
    if (ctl.mul_r) begin
      op_a = DIFF_W'(vj.x) - DIFF_W'(vi.x);
      op_b = DIFF_W'(pt.y) - DIFF_W'(vi.y);
    end else begin
      op_a = DIFF_W'(pt.x) - DIFF_W'(vi.x);
      op_b = dy;
    end
  end

  assign prod_nxt = PROD_W'(op_a) * PROD_W'(op_b);

  // The comparison runs in the cycle after the second product, so it overlaps
  // the first product of the next edge.
  assign hit = straddle_r && ((dy_pos_r && (l_r < prod_r)) ||
                              (dy_neg_r && (l_r > prod_r)));

  always_ff @(posedge clk) begin
    if (ctl.mul_l || ctl.mul_r) begin
      prod_r <= prod_nxt;
    end
    if (ctl.mul_r) begin
      l_r        <= prod_r;
      straddle_r <= straddle;
      dy_pos_r   <= (dy > 0);
      dy_neg_r   <= (dy < 0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r   <= 1'b0;
      parity_r <= 1'b0;
    end else begin
      pend_r <= ctl.mul_r;
      if (ctl.clr) begin
        parity_r <= 1'b0;
      end else if (pend_r) begin
        parity_r <= parity_r ^ hit;
      end
    end
  end

  assign parity = parity_r;

  a_one_product: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.mul_l && ctl.mul_r))
    else $error("edge unit asked for both products at once");

  a_pend_follows_r: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.mul_r |=> pend_r)
    else $error("comparison not scheduled after second product");

  a_straddle_slope: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r && straddle_r |-> (dy_pos_r != dy_neg_r))
    else $error("straddling edge with no vertical extent");

endmodule

/* src/point_in_polygon_test_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_polygon_test_core
// Crossing-number point-in-polygon tester over a table of up to 16 vertices.
// ----------------------------------------------------------------------------
// Each input word clears the vertex table, appends one vertex, or tests one
// point; each gives exactly one result word. Clear, append, unused request
// codes and a test of an empty table finish in the cycle they are taken, and
// their result is presented on the next cycle. For a test with N >= 1 stored
// vertices, the vertex memory is walked one edge at a time and a single 17x17
// multiplier forms the two cross products of each edge in consecutive cycles.
// The core takes no new word while a test runs or while an earlier result
// word waits.
// ----------------------------------------------------------------------------
module point_in_polygon_test_core
  import pip_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // coord_x, coord_y
  input  logic [REQ_W-1:0]       in_tuser,   // req_type
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // inside_res, vertex_count, table_full
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRIME0,
    S_PRIME1,
    S_PRIME2,
    S_MUL_L,
    S_MUL_R,
    S_WAIT,
    S_DONE
  } state_t;

  state_t           state_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] edge_r;
  vertex_t          vi_r;
  vertex_t          vj_r;
  vertex_t          pt_r;
  logic             out_valid_r;
  logic             out_inside_r;
  logic [CNT_W-1:0] out_cnt_r;
  logic             out_full_r;

  req_t             req;
  vertex_t          in_vtx;
  logic             accept;
  logic             walk_start;
  logic             out_free;
  logic             tbl_full;
  logic             ram_we;
  vertex_t          ram_rdata;
  eu_ctl_t          eu_ctl;
  logic             parity;
  logic [CNT_W-1:0] last_edge;

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] k,
                                                input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] k1;
    k1 = CNT_W'(k) + CNT_W'(1);
    if (k1 >= n) begin
      return '0;
    end
    return k1[IDX_W-1:0];
  endfunction

  assign req       = req_t'(in_tuser);
  assign in_vtx.x  = in_tdata[COORD_W-1:0];
  assign in_vtx.y  = in_tdata[2*COORD_W-1:COORD_W];
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign accept    = in_tvalid && in_tready;
  assign tbl_full  = (cnt_r >= CNT_W'(MAX_VERTICES));
  assign ram_we    = accept && (req == REQ_APPEND) && !tbl_full;
  assign last_edge = cnt_r - CNT_W'(1);

  // A test of a non-empty table walks the edges; every other word answers at once.
  assign walk_start = accept && (req == REQ_TEST) && (cnt_r != '0);

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) begin
      case (req)
        REQ_CLEAR: begin
          cnt_nxt = '0;
        end
        REQ_APPEND: begin
          if (!tbl_full) begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    eu_ctl       = '0;
    eu_ctl.clr   = accept;
    eu_ctl.mul_l = (state_r == S_MUL_L);
    eu_ctl.mul_r = (state_r == S_MUL_R);
  end

  pip_vtx_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[IDX_W-1:0]),
    .wdata (in_vtx),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  pip_edge_unit u_edge (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (eu_ctl),
    .vi     (vi_r),
    .vj     (vj_r),
    .pt     (pt_r),
    .parity (parity)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      idx_r       <= '0;
      edge_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (accept && !walk_start) begin
        out_inside_r <= 1'b0;
        out_full_r   <= (req == REQ_APPEND) && tbl_full;
        out_cnt_r    <= cnt_nxt;
        out_valid_r  <= 1'b1;
      end else if ((state_r == S_DONE) && out_free) begin
        out_inside_r <= parity;
        out_full_r   <= 1'b0;
        out_cnt_r    <= cnt_r;
        out_valid_r  <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (walk_start) begin
            pt_r    <= in_vtx;
            idx_r   <= '0;
            state_r <= S_PRIME0;
          end
        end
        S_PRIME0: begin
          idx_r   <= next_idx(idx_r, cnt_r);
          state_r <= S_PRIME1;
        end
        S_PRIME1: begin
          vi_r    <= ram_rdata;
          idx_r   <= next_idx(idx_r, cnt_r);
          state_r <= S_PRIME2;
        end
        S_PRIME2: begin
          vj_r    <= ram_rdata;
          edge_r  <= '0;
          state_r <= S_MUL_L;
        end
        S_MUL_L: begin
          state_r <= S_MUL_R;
        end
        S_MUL_R: begin
          // Slide the edge window; the read data already holds the vertex
          // after the current far end, wrapping back to the first vertex.
          vi_r  <= vj_r;
          vj_r  <= ram_rdata;
          idx_r <= next_idx(idx_r, cnt_r);
          if (CNT_W'(edge_r) == last_edge) begin
            state_r <= S_WAIT;
          end else begin
            edge_r  <= edge_r + IDX_W'(1);
            state_r <= S_MUL_L;
          end
        end
        S_WAIT: begin
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_full_r, out_cnt_r, out_inside_r});

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_tready)
    else $error("input taken while a test is running");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_VERTICES))
    else $error("vertex count beyond table depth");

  a_edge_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL_L) |-> (CNT_W'(edge_r) < cnt_r))
    else $error("edge index beyond stored vertices");

  a_test_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) && out_free |=> out_valid_r && (state_r == S_IDLE))
    else $error("test finished without a result word");

endmodule
